FILE: sv/sha256_hash_engine_registers_top_macros.svh
// Assertion macros used by the hash engine back end (shae_back).
// Depends on a clk and an rst_n signal in the scope of use.
`ifndef SHA256_HASH_ENGINE_REGISTERS_TOP_MACROS_SVH
`define SHA256_HASH_ENGINE_REGISTERS_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SHAE_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never occurs outside reset.
`define SHAE_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: sv/shae_pkg.sv
// Shared types, codes and SHA-256 helper functions for the hash engine.
// No dependencies.
package shae_pkg;

    typedef logic [31:0] word_t;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ADDR  = 2'd1;
    localparam logic [1:0] ST_MODE  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Operation codes
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_BYTE_RD  = 2'd2;

    // Command kinds after decode
    localparam logic [2:0] K_BAD     = 3'd0;
    localparam logic [2:0] K_CTRL_WR = 3'd1;
    localparam logic [2:0] K_FIFO_WR = 3'd2;
    localparam logic [2:0] K_CTRL_RD = 3'd3;
    localparam logic [2:0] K_LEN_RD  = 3'd4;
    localparam logic [2:0] K_HASH_RD = 3'd5;
    localparam logic [2:0] K_FIFO_RD = 3'd6;
    localparam logic [2:0] K_BYTE_RD = 3'd7;

    // Register offsets
    localparam logic [7:0] OFF_CTRL = 8'h00;
    localparam logic [7:0] OFF_LEN  = 8'h04;

    // Flag bit positions
    localparam int F_INDMA  = 0;
    localparam int F_BIGEND = 1;
    localparam int F_READY  = 2;
    localparam int F_OUTDMA = 3;

    // Hash modes
    localparam logic [1:0] MODE_SHA256 = 2'd0;
    localparam logic [1:0] MODE_SHA1   = 2'd2;

    localparam word_t PAD_WORD = 32'h8000_0000;

    typedef struct packed {
        logic [2:0] kind;
        logic [2:0] idx;
        logic [1:0] bsel;
        word_t      data;
    } cmd_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t bswap(input word_t x);
        bswap = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic word_t big_sigma0(input word_t x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t big_sigma1(input word_t x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic word_t small_sigma0(input word_t x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t small_sigma1(input word_t x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t iv_sha256(input logic [2:0] i);
        case (i)
            3'd0: iv_sha256 = 32'h6a09e667;
            3'd1: iv_sha256 = 32'hbb67ae85;
            3'd2: iv_sha256 = 32'h3c6ef372;
            3'd3: iv_sha256 = 32'ha54ff53a;
            3'd4: iv_sha256 = 32'h510e527f;
            3'd5: iv_sha256 = 32'h9b05688c;
            3'd6: iv_sha256 = 32'h1f83d9ab;
            default: iv_sha256 = 32'h5be0cd19;
        endcase
    endfunction

    function automatic word_t iv_sha1(input logic [2:0] i);
        case (i)
            3'd0: iv_sha1 = 32'h67452301;
            3'd1: iv_sha1 = 32'hEFCDAB89;
            3'd2: iv_sha1 = 32'h98BADCFE;
            3'd3: iv_sha1 = 32'h10325476;
            3'd4: iv_sha1 = 32'hC3D2E1F0;
            default: iv_sha1 = 32'h0;
        endcase
    endfunction

    function automatic word_t round_k(input logic [5:0] i);
        case (i)
            6'd0:  round_k = 32'h428a2f98; 6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf; 6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b; 6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4; 6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98; 6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be; 6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74; 6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7; 6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1; 6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6; 6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f; 6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc; 6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152; 6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8; 6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3; 6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351; 6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85; 6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc; 6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354; 6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e; 6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1; 6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70; 6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819; 6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585; 6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116; 6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c; 6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3; 6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f; 6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee; 6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814; 6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa; 6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7; default: round_k = 32'hc67178f2;
        endcase
    endfunction

endpackage

FILE: sv/shae_if.sv
// Valid/ready channel interfaces for the hash engine request and response.
// Depends on shae_pkg.
interface shae_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           operation;
    logic [7:0]           address_offset;
    shae_pkg::word_t      write_data;

    modport source (output valid, operation, address_offset, write_data, input ready);
    modport sink   (input valid, operation, address_offset, write_data, output ready);
endinterface

interface shae_out_if;
    logic                 valid;
    logic                 ready;
    shae_pkg::word_t      read_data;
    logic [1:0]           status;

    modport source (output valid, read_data, status, input ready);
    modport sink   (input valid, read_data, status, output ready);
endinterface

FILE: sv/shae_core.sv
// SHA-256 compression unit: one round per cycle, then the chaining add.
// Depends on shae_pkg.
module shae_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  shae_pkg::word_t cv_in  [8],
    input  shae_pkg::word_t blk_in [16],
    output logic            done,
    output shae_pkg::word_t cv_out [8]
);

    logic            busy_reg;
    logic            fin_reg;
    logic [5:0]      cnt_reg;
    shae_pkg::word_t v_reg [8];
    shae_pkg::word_t w_reg [16];
    shae_pkg::word_t t1;
    shae_pkg::word_t t2;
    shae_pkg::word_t w_new;

    // Round logic and schedule expansion
    always_comb
    begin
        t1 = v_reg[7] + shae_pkg::big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + shae_pkg::round_k(cnt_reg) + w_reg[0];
        t2 = shae_pkg::big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = w_reg[0] + shae_pkg::small_sigma0(w_reg[1]) + w_reg[9]
              + shae_pkg::small_sigma1(w_reg[14]);
    end

    // Sequence the 64 rounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_reg <= 1'b0;
                fin_reg  <= 1'b1;
            end
        end
        else
        begin
            fin_reg <= 1'b0;
        end
    end

    // Working variables and schedule window
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg <= cv_in;
            w_reg <= blk_in;
        end
        else if (busy_reg)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
        end
    end

    // Feed-forward add
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            cv_out[i] = cv_in[i] + v_reg[i];
        end
    end

    assign done = fin_reg;

endmodule

FILE: sv/shae_front.sv
// Request decode and two-entry command queue of the hash engine.
// Depends on shae_pkg and shae_if.
module shae_front (
    input  logic               clk,
    input  logic               rst_n,
    shae_in_if.sink            in_ch,
    output shae_pkg::cmd_t     cmd,
    output logic               cmd_valid,
    input  logic               cmd_pop
);

    shae_pkg::cmd_t q_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     cnt_reg;
    shae_pkg::cmd_t dec;
    logic           push;
    logic           in_fifo;

    // Classify the access
    always_comb
    begin
        in_fifo  = (in_ch.address_offset[7:6] == 2'b10);
        dec.idx  = in_ch.address_offset[4:2];
        dec.bsel = in_ch.address_offset[1:0];
        dec.data = in_ch.write_data;
        dec.kind = shae_pkg::K_BAD;
        case (in_ch.operation)
            shae_pkg::OP_WRITE:
            begin
                if (in_fifo)
                    dec.kind = shae_pkg::K_FIFO_WR;
                else if (in_ch.address_offset == shae_pkg::OFF_CTRL)
                    dec.kind = shae_pkg::K_CTRL_WR;
            end
            shae_pkg::OP_READ:
            begin
                if (in_ch.address_offset[7:6] == 2'b01)
                    dec.kind = shae_pkg::K_HASH_RD;
                else if (in_fifo)
                    dec.kind = shae_pkg::K_FIFO_RD;
                else if (in_ch.address_offset == shae_pkg::OFF_CTRL)
                    dec.kind = shae_pkg::K_CTRL_RD;
                else if (in_ch.address_offset == shae_pkg::OFF_LEN)
                    dec.kind = shae_pkg::K_LEN_RD;
            end
            shae_pkg::OP_BYTE_RD:
                dec.kind = shae_pkg::K_BYTE_RD;
            default:
                dec.kind = shae_pkg::K_BAD;
        endcase
    end

    assign in_ch.ready = (cnt_reg != 2'd2);
    assign push        = in_ch.valid && in_ch.ready;
    assign cmd_valid   = (cnt_reg != 2'd0);
    assign cmd         = q_reg[rd_ptr_reg];

    // Advance queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (cmd_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= dec;
    end

endmodule

FILE: sv/shae_back.sv
// Command execution of the hash engine: register state, echo queue,
// padding and compression control. Depends on shae_pkg, shae_if, shae_core and the macros header.
`include "sha256_hash_engine_registers_top_macros.svh"
module shae_back (
    input  logic               clk,
    input  logic               rst_n,
    input  shae_pkg::cmd_t     cmd,
    input  logic               cmd_valid,
    output logic               cmd_pop,
    shae_out_if.source         out_ch
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_C1   = 2'd1;
    localparam logic [1:0] S_C2   = 2'd2;

    logic [1:0]      state_reg;
    logic            two_reg;
    logic            start_reg;
    shae_pkg::word_t cv_reg   [8];
    shae_pkg::word_t blk_reg  [16];
    shae_pkg::word_t echo_reg [16];
    logic [4:0]      pend_reg;
    logic [3:0]      head_reg;
    logic [4:0]      ecnt_reg;
    logic [63:0]     len_reg;
    logic [1:0]      mode_reg;
    logic [3:0]      flag_reg;
    logic            out_valid_reg;
    shae_pkg::word_t out_data_reg;
    logic [1:0]      out_st_reg;

    logic            core_done;
    shae_pkg::word_t core_cv [8];
    logic            slot_free;
    logic            go;
    logic [3:0]      n;
    logic [63:0]     len_pad;
    logic [1:0]      new_mode;
    logic [3:0]      ehead;
    logic [4:0]      ecnt;
    logic            pad_go;
    logic            fifo_full;
    shae_pkg::word_t hw;
    logic [1:0]      bs;

    shae_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .cv_in  (cv_reg),
        .blk_in (blk_reg),
        .done   (core_done),
        .cv_out (core_cv)
    );

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign go        = (state_reg == S_IDLE) && cmd_valid && slot_free;
    assign cmd_pop   = go;

    // Helper values for the command at the head of the queue
    always_comb
    begin
        n         = pend_reg[3:0];
        new_mode  = cmd.data[5:4];
        len_pad   = (cmd.data[0] ? 64'd0 : len_reg) << 5;
        pad_go    = cmd.data[1] && (new_mode == shae_pkg::MODE_SHA256);
        ehead     = (pend_reg == 5'd0) ? 4'd0 : head_reg;
        ecnt      = (pend_reg == 5'd0) ? 5'd0 : ecnt_reg;
        fifo_full = (pend_reg == 5'd15);
        hw        = cv_reg[cmd.idx];
        bs        = cmd.bsel ^ {2{flag_reg[shae_pkg::F_BIGEND]}};
    end

    // Execute commands and sequence compressions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            two_reg       <= 1'b0;
            start_reg     <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                cv_reg[i] <= '0;
            end
            pend_reg      <= '0;
            head_reg      <= '0;
            ecnt_reg      <= '0;
            len_reg       <= '0;
            mode_reg      <= '0;
            flag_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
            out_st_reg    <= shae_pkg::ST_OK;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_ch.ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (go)
                    begin
                        out_data_reg <= '0;
                        out_st_reg   <= shae_pkg::ST_OK;
                        out_valid_reg <= 1'b1;
                        case (cmd.kind)
                            shae_pkg::K_CTRL_WR:
                            begin
                                flag_reg[shae_pkg::F_INDMA]  <= cmd.data[2];
                                flag_reg[shae_pkg::F_BIGEND] <= cmd.data[3];
                                flag_reg[shae_pkg::F_OUTDMA] <= cmd.data[10];
                                mode_reg <= new_mode;
                                if (cmd.data[0])
                                begin
                                    len_reg <= '0;
                                    for (int i = 0; i < 8; i++)
                                    begin
                                        if (new_mode == shae_pkg::MODE_SHA256)
                                            cv_reg[i] <= shae_pkg::iv_sha256(3'(i));
                                        else if (new_mode == shae_pkg::MODE_SHA1)
                                            cv_reg[i] <= shae_pkg::iv_sha1(3'(i));
                                    end
                                end
                                if (pad_go)
                                begin
                                    out_valid_reg <= 1'b0;
                                    len_reg   <= len_pad;
                                    for (int i = 0; i < 16; i++)
                                    begin
                                        if (4'(i) == n)
                                            blk_reg[i] <= shae_pkg::PAD_WORD;
                                        else if (4'(i) > n)
                                            blk_reg[i] <= '0;
                                    end
                                    if (n < 4'd14)
                                    begin
                                        blk_reg[14] <= len_pad[63:32];
                                        blk_reg[15] <= len_pad[31:0];
                                    end
                                    two_reg   <= (n >= 4'd14);
                                    start_reg <= 1'b1;
                                    state_reg <= S_C1;
                                end
                                else if (cmd.data[1])
                                begin
                                    out_st_reg <= shae_pkg::ST_MODE;
                                end
                            end
                            shae_pkg::K_FIFO_WR:
                            begin
                                blk_reg[n] <= shae_pkg::bswap(cmd.data);
                                len_reg    <= len_reg + 64'd1;
                                if (ecnt < 5'd16)
                                begin
                                    echo_reg[ehead + ecnt[3:0]] <= cmd.data;
                                    ecnt_reg <= ecnt + 5'd1;
                                end
                                else
                                begin
                                    ecnt_reg <= ecnt;
                                end
                                head_reg <= ehead;
                                flag_reg[shae_pkg::F_READY] <= fifo_full;
                                if (fifo_full)
                                begin
                                    pend_reg <= '0;
                                    if (mode_reg == shae_pkg::MODE_SHA256)
                                    begin
                                        out_valid_reg <= 1'b0;
                                        two_reg       <= 1'b0;
                                        start_reg     <= 1'b1;
                                        state_reg     <= S_C1;
                                    end
                                    else
                                    begin
                                        out_st_reg <= shae_pkg::ST_MODE;
                                    end
                                end
                                else
                                begin
                                    pend_reg <= pend_reg + 5'd1;
                                end
                            end
                            shae_pkg::K_CTRL_RD:
                                out_data_reg <= {21'd0, flag_reg[shae_pkg::F_OUTDMA],
                                                 flag_reg[shae_pkg::F_READY], 3'd0,
                                                 mode_reg, flag_reg[shae_pkg::F_BIGEND],
                                                 flag_reg[shae_pkg::F_INDMA], 2'd0};
                            shae_pkg::K_LEN_RD:
                                out_data_reg <= {len_reg[29:0], 2'b00};
                            shae_pkg::K_HASH_RD:
                                out_data_reg <= flag_reg[shae_pkg::F_BIGEND]
                                              ? shae_pkg::bswap(hw) : hw;
                            shae_pkg::K_FIFO_RD:
                            begin
                                if (ecnt_reg == 5'd0)
                                begin
                                    out_st_reg <= shae_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    out_data_reg <= echo_reg[head_reg];
                                    head_reg     <= head_reg + 4'd1;
                                    ecnt_reg     <= ecnt_reg - 5'd1;
                                    if (ecnt_reg == 5'd1)
                                        flag_reg[shae_pkg::F_READY] <= 1'b0;
                                end
                            end
                            shae_pkg::K_BYTE_RD:
                                out_data_reg <= {24'd0, hw[{bs, 3'b000} +: 8]};
                            default:
                                out_st_reg <= shae_pkg::ST_ADDR;
                        endcase
                    end
                end
                S_C1:
                begin
                    if (core_done)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            cv_reg[i] <= core_cv[i];
                        end
                        if (two_reg)
                        begin
                            for (int i = 0; i < 14; i++)
                            begin
                                blk_reg[i] <= '0;
                            end
                            blk_reg[14] <= len_reg[63:32];
                            blk_reg[15] <= len_reg[31:0];
                            start_reg   <= 1'b1;
                            state_reg   <= S_C2;
                        end
                        else
                        begin
                            pend_reg      <= '0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= S_IDLE;
                        end
                    end
                end
                S_C2:
                begin
                    if (core_done)
                    begin
                        for (int i = 0; i < 8; i++)
                        begin
                            cv_reg[i] <= core_cv[i];
                        end
                        pend_reg      <= '0;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.read_data = out_data_reg;
    assign out_ch.status    = out_st_reg;

    `SHAE_NEVER(a_pend_range, pend_reg > 5'd15, "pending word count out of range")
    `SHAE_NEVER(a_echo_range, ecnt_reg > 5'd16, "echo count out of range")
    `SHAE_CHECK(a_done_state, core_done |-> (state_reg == S_C1 || state_reg == S_C2),
                "compression finished outside a compress state")
    `SHAE_CHECK(a_start_done, start_reg |=> !core_done, "compression finished too early")

endmodule

FILE: sv/sha256_hash_engine_registers_top.sv
// Top level of the register-mapped SHA-256 engine.
// Depends on shae_pkg, shae_if, shae_front, shae_back.
//
//  channel  | dir | payload
//  in_ch    | in  | operation, address_offset, write_data
//  out_ch   | out | read_data, status
//
// Register and FIFO accesses pass through the command queue and the registered
// response. A 16th FIFO word or a final pad in SHA-256 mode holds its response
// until each compression ends (one SHA-256 round per cycle) in the shared round unit.
// The two-entry command queue takes requests while the back end runs.
// Reset (rst_n, asynchronous) clears the chaining value, counts and flags.
module sha256_hash_engine_registers_top (
    input  logic        clk,
    input  logic        rst_n,
    shae_in_if.sink     in_ch,
    shae_out_if.source  out_ch
);

    shae_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    shae_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop)
    );

    shae_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_pop   (cmd_pop),
        .out_ch    (out_ch)
    );

endmodule

FILE: test/shae_tb_checker.sv
// Checker for the register-mapped SHA-256 engine: watches both channels,
// predicts each response and compares it. Depends on shae_pkg and shae_if.
module shae_tb_checker (
    input  logic       clk,
    input  logic       rst_n,
    shae_in_if.sink    mon_in,
    shae_out_if.sink   mon_out,
    output int         fail_count,
    output int         pending_resp,
    output int         resp_seen
);

    typedef struct {
        shae_pkg::word_t rdata;
        logic [1:0]      stat;
    } resp_t;

    // Predicted engine state
    shae_pkg::word_t cv_q [8];
    shae_pkg::word_t blk_q [16];
    int unsigned     wr_pend;
    shae_pkg::word_t echo_q [$];
    logic [63:0]     len_q;
    logic [1:0]      mode_q;
    logic            f_indma, f_bigend, f_ready, f_outdma;
    resp_t           resp_fifo [$];

    localparam shae_pkg::word_t K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    localparam shae_pkg::word_t H256 [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam shae_pkg::word_t H160 [8] = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
        32'h10325476, 32'hC3D2E1F0, 32'h0, 32'h0, 32'h0};

    function automatic shae_pkg::word_t ror32(shae_pkg::word_t x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic shae_pkg::word_t flip(shae_pkg::word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    // Run 64 rounds over the current block and fold into the chaining value
    task automatic sha_round_block();
        shae_pkg::word_t w [64];
        shae_pkg::word_t v [8];
        shae_pkg::word_t t1, t2;
        for (int i = 0; i < 16; i++) w[i] = blk_q[i];
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = cv_q[i];
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) cv_q[i] += v[i];
    endtask

    task automatic finish_message();
        int unsigned n;
        n = wr_pend & 15;
        for (int i = n; i < 16; i++) blk_q[i] = '0;
        blk_q[n] = shae_pkg::PAD_WORD;
        len_q = len_q * 32;
        if (n >= 14)
        begin
            sha_round_block();
            for (int i = 0; i < 16; i++) blk_q[i] = '0;
        end
        blk_q[14] = len_q[63:32];
        blk_q[15] = len_q[31:0];
        sha_round_block();
        wr_pend = 0;
    endtask

    // Predict the response of one access and advance the state
    task automatic predict_access(input logic [1:0] op, input logic [7:0] off,
                                  input shae_pkg::word_t d, output resp_t r);
        logic [2:0] idx;
        logic [1:0] b;
        idx = off[4:2];
        r.rdata = '0;
        r.stat = shae_pkg::ST_OK;
        if (op == shae_pkg::OP_WRITE)
        begin
            if (off >= 8'h80 && off < 8'hC0)
            begin
                if (wr_pend == 0) echo_q.delete();
                blk_q[wr_pend] = flip(d);
                wr_pend++;
                if (echo_q.size() < 16) echo_q.push_back(d);
                len_q++;
                if (wr_pend >= 16)
                begin
                    if (mode_q == shae_pkg::MODE_SHA256) sha_round_block();
                    else r.stat = shae_pkg::ST_MODE;
                    wr_pend = 0;
                    f_ready = 1'b1;
                end
                else
                    f_ready = 1'b0;
            end
            else if (off == shae_pkg::OFF_CTRL)
            begin
                f_indma = d[2];
                f_bigend = d[3];
                f_outdma = d[10];
                mode_q = d[5:4];
                if (d[0])
                begin
                    if (mode_q == shae_pkg::MODE_SHA256) cv_q = H256;
                    else if (mode_q == shae_pkg::MODE_SHA1) cv_q = H160;
                    len_q = '0;
                end
                if (d[1])
                begin
                    if (mode_q == shae_pkg::MODE_SHA256) finish_message();
                    else r.stat = shae_pkg::ST_MODE;
                end
            end
            else
                r.stat = shae_pkg::ST_ADDR;
        end
        else if (op == shae_pkg::OP_READ)
        begin
            if (off >= 8'h40 && off < 8'h80)
                r.rdata = f_bigend ? flip(cv_q[idx]) : cv_q[idx];
            else if (off >= 8'h80 && off < 8'hC0)
            begin
                if (echo_q.size() == 0)
                    r.stat = shae_pkg::ST_EMPTY;
                else
                begin
                    r.rdata = echo_q.pop_front();
                    if (echo_q.size() == 0) f_ready = 1'b0;
                end
            end
            else if (off == shae_pkg::OFF_CTRL)
                r.rdata = {21'd0, f_outdma, f_ready, 3'd0, mode_q, f_bigend, f_indma, 2'd0};
            else if (off == shae_pkg::OFF_LEN)
                r.rdata = len_q[31:0] * 4;
            else
                r.stat = shae_pkg::ST_ADDR;
        end
        else if (op == shae_pkg::OP_BYTE_RD)
        begin
            b = f_bigend ? 2'd3 - off[1:0] : off[1:0];
            r.rdata = (cv_q[idx] >> (b * 8)) & 32'hFF;
        end
        else
            r.stat = shae_pkg::ST_ADDR;
    endtask

    // Predict on each request transfer, compare on each response transfer
    always @(posedge clk or negedge rst_n)
    begin
        resp_t r, e;
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++) cv_q[i] = '0;
            for (int i = 0; i < 16; i++) blk_q[i] = '0;
            wr_pend = 0;
            echo_q.delete();
            len_q = '0;
            mode_q = shae_pkg::MODE_SHA256;
            {f_indma, f_bigend, f_ready, f_outdma} = '0;
            resp_fifo.delete();
            fail_count = 0;
            resp_seen = 0;
            pending_resp = 0;
        end
        else
        begin
            if (mon_in.valid && mon_in.ready)
            begin
                predict_access(mon_in.operation, mon_in.address_offset, mon_in.write_data, r);
                resp_fifo.push_back(r);
            end
            if (mon_out.valid && mon_out.ready)
            begin
                resp_seen++;
                if (resp_fifo.size() == 0)
                begin
                    $error("response with nothing expected: read_data %h status %0d",
                           mon_out.read_data, mon_out.status);
                    fail_count++;
                end
                else
                begin
                    e = resp_fifo.pop_front();
                    if (mon_out.read_data !== e.rdata)
                    begin
                        $error("read_data expected %h actual %h", e.rdata, mon_out.read_data);
                        fail_count++;
                    end
                    if (mon_out.status !== e.stat)
                    begin
                        $error("status expected %0d actual %0d", e.stat, mon_out.status);
                        fail_count++;
                    end
                end
            end
            pending_resp = resp_fifo.size();
        end
    end
endmodule

FILE: test/sha256_hash_engine_registers_top_tb.sv
// Testbench top for the register-mapped SHA-256 engine: drives accesses,
// varies handshake idling and reports. Depends on shae_pkg, shae_if, shae_tb_checker.
module sha256_hash_engine_registers_top_tb;

    // Operation code with no meaning, decoded as a bad access
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    int   fail_count, pending_resp, resp_seen;
    int   send_idle_pct, sink_stall_pct;
    int   sent_total;
    int   phase_base;

    shae_in_if  req_ch ();
    shae_out_if rsp_ch ();

    sha256_hash_engine_registers_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (req_ch.sink),
        .out_ch (rsp_ch.source)
    );

    shae_tb_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .mon_in       (req_ch.sink),
        .mon_out      (rsp_ch.sink),
        .fail_count   (fail_count),
        .pending_resp (pending_resp),
        .resp_seen    (resp_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stall the response side at random
    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Drive one access and hold it until transfer; valid stays up after it
    task automatic send_access(input logic [1:0] op, input logic [7:0] off,
                               input shae_pkg::word_t d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.operation <= op;
        req_ch.address_offset <= off;
        req_ch.write_data <= d;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        sent_total++;
    endtask

    function automatic logic [7:0] fifo_off();
        return 8'h80 + 8'($urandom_range(63));
    endfunction

    // Control word: random flags, chosen mode, optional init/finish
    function automatic shae_pkg::word_t ctrl_word(logic [1:0] m, logic init, logic fin);
        shae_pkg::word_t w;
        w = $urandom;
        w[5:4] = m;
        w[0] = init;
        w[1] = fin;
        return w;
    endfunction

    task automatic read_back_hash();
        for (int i = 0; i < 8; i++)
            send_access(shae_pkg::OP_READ, 8'h40 + 8'(i * 4), '0);
        send_access(shae_pkg::OP_READ, shae_pkg::OFF_CTRL, '0);
        send_access(shae_pkg::OP_READ, shae_pkg::OFF_LEN, '0);
    endtask

    // Well-formed message: init, words, optional echo reads, finish, read hash
    task automatic hash_message(input logic [1:0] m);
        int n;
        n = ($urandom_range(3) == 0) ? $urandom_range(40) : $urandom_range(18);
        send_access(shae_pkg::OP_WRITE, shae_pkg::OFF_CTRL, ctrl_word(m, 1'b1, 1'b0));
        for (int i = 0; i < n; i++)
        begin
            send_access(shae_pkg::OP_WRITE, fifo_off(), $urandom);
            if ($urandom_range(7) == 0) send_access(shae_pkg::OP_READ, fifo_off(), '0);
        end
        for (int i = $urandom_range(3); i > 0; i--)
            send_access(shae_pkg::OP_READ, fifo_off(), '0);
        send_access(shae_pkg::OP_WRITE, shae_pkg::OFF_CTRL, ctrl_word(m, 1'b0, 1'b1));
        read_back_hash();
        send_access(shae_pkg::OP_BYTE_RD, 8'($urandom), '0);
    endtask

    task automatic noise_access();
        logic [1:0] op;
        op = 2'($urandom);
        if (op == shae_pkg::OP_WRITE && $urandom_range(1))
            send_access(op, fifo_off(), $urandom);
        else
            send_access(op, 8'($urandom), $urandom);
    endtask

    // Drop valid and hold off until every expected response has come
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_resp != 0) @(posedge clk);
    endtask

    initial
    begin
        req_ch.valid = 1'b0;
        req_ch.operation = shae_pkg::OP_WRITE;
        req_ch.address_offset = '0;
        req_ch.write_data = '0;
        rsp_ch.ready = 1'b0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        sent_total = 0;
        phase_base = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reads before init, bad addresses, empty echo, extremes
        send_access(shae_pkg::OP_READ, 8'h40, '0);
        send_access(shae_pkg::OP_READ, 8'h80, '0);
        send_access(shae_pkg::OP_READ, shae_pkg::OFF_CTRL, '0);
        send_access(shae_pkg::OP_WRITE, shae_pkg::OFF_LEN, 32'hFFFF_FFFF);
        send_access(shae_pkg::OP_WRITE, 8'h44, 32'h1234_5678);
        send_access(shae_pkg::OP_READ, 8'h02, '0);
        send_access(shae_pkg::OP_READ, 8'hFF, '0);
        send_access(OP_UNUSED, 8'h00, '0);
        send_access(shae_pkg::OP_WRITE, shae_pkg::OFF_CTRL, 32'h0000_0001);
        send_access(shae_pkg::OP_WRITE, 8'hBC, 32'hFFFF_FFFF);
        send_access(shae_pkg::OP_WRITE, 8'h80, 32'h0000_0000);
        send_access(shae_pkg::OP_READ, 8'hBF, '0);
        send_access(shae_pkg::OP_WRITE, shae_pkg::OFF_CTRL, 32'h0000_0002);
        send_access(shae_pkg::OP_READ, 8'h7C, '0);
        send_access(shae_pkg::OP_BYTE_RD, 8'hFF, '0);
        send_access(shae_pkg::OP_WRITE, shae_pkg::OFF_CTRL, 32'hFFFF_FFFF);
        send_access(shae_pkg::OP_READ, shae_pkg::OFF_CTRL, '0);
        send_access(shae_pkg::OP_BYTE_RD, 8'h41, '0);
        send_access(shae_pkg::OP_READ, 8'h48, '0);
        send_access(shae_pkg::OP_WRITE, shae_pkg::OFF_CTRL, 32'h0000_0021);
        for (int i = 0; i < 16; i++) send_access(shae_pkg::OP_WRITE, 8'h84, $urandom);
        send_access(shae_pkg::OP_WRITE, shae_pkg::OFF_CTRL, 32'h0000_0012);
        send_access(shae_pkg::OP_READ, shae_pkg::OFF_LEN, '0);

        // Random: mostly well-formed messages across idling phases
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 3) ? 16 : 88) : 0;
            sink_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 16 : 88) : 0;
            if (ph == 1) sink_stall_pct = 0;
            phase_base = sent_total;
            while (sent_total - phase_base < 170)
            begin
                if ($urandom_range(9) < 7)
                begin
                    case ($urandom_range(5))
                        0: hash_message(shae_pkg::MODE_SHA1);
                        1: hash_message(2'($urandom));
                        default: hash_message(shae_pkg::MODE_SHA256);
                    endcase
                end
                else
                begin
                    noise_access();
                end
            end
            wait_drained();
        end

        wait_drained();
        repeat (200) @(posedge clk);
        $display("Sent %0d accesses, %0d responses compared, over four idling phases.",
                 sent_total, resp_seen);
        if (fail_count == 0 && pending_resp == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
